// ===== rtl/ffha_pkg.sv =====
// Package for the first-fit heap allocator: constants, payload structs, codes.
// No dependencies.
package ffha_pkg;

    localparam int MaxSegments = 64;
    localparam int SlotW       = $clog2(MaxSegments);
    localparam int LinkW       = SlotW + 1;
    localparam int PageBytes   = 4096;
    localparam int PageShift   = $clog2(PageBytes);
    localparam int HeaderBytes = 32;
    localparam int MaxPages    = 1024;
    localparam int PagesW      = 11;
    localparam int StartW      = 22;
    localparam int LenW        = 23;
    localparam int AddrW       = 48;

    localparam logic [LinkW-1:0] NullLink = LinkW'(MaxSegments);

    localparam logic [1:0] StatusDone    = 2'd0;
    localparam logic [1:0] StatusNoSpace = 2'd1;
    localparam logic [1:0] StatusBadAddr = 2'd2;

    localparam logic ModeAlloc = 1'b0;
    localparam logic ModeFree  = 1'b1;

    localparam logic RegBase  = 1'b0;
    localparam logic RegLimit = 1'b1;
    localparam int   CfgW     = AddrW;

    // One segment table entry.
    typedef struct packed {
        logic [StartW-1:0] start;
        logic [LenW-1:0]   length;
        logic              is_free;
        logic [LinkW-1:0]  after;
        logic [LinkW-1:0]  prev;
    } seg_t;

    typedef struct packed {
        logic             mode;
        logic [LenW-1:0]  request_bytes;
        logic [AddrW-1:0] payload_address;
    } req_t;

    typedef struct packed {
        logic [AddrW-1:0]  granted_address;
        logic [1:0]        status;
        logic [PagesW-1:0] heap_pages;
    } rsp_t;

endpackage

// ===== rtl/ffha_seg_ram.sv =====
// Segment table memory: one write port, one registered read port.
// Depends on ffha_pkg.
module ffha_seg_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ffha_pkg::SlotW-1:0]  waddr,
    input  ffha_pkg::seg_t              wdata,
    input  logic [ffha_pkg::SlotW-1:0]  raddr,
    output ffha_pkg::seg_t              rdata
);
    import ffha_pkg::*;

    seg_t mem [MaxSegments];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: control sequencer and slot map.
// Depends on ffha_pkg and ffha_seg_ram.
//
// Usage. Requests arrive on the req channel (req_valid, req_stall, req) and
// each one gives exactly one result on the rsp channel (rsp_valid,
// rsp_stall, rsp). An allocate request walks the address-ordered segment
// list from slot zero, one memory read per segment, and takes the first free
// segment that is large enough, splitting off the remainder when it exceeds a
// header and a slot is spare. If nothing fits, the heap grows by whole pages.
// A free request walks the list looking for the matching segment, then merges
// it with free neighbours. Each segment visited costs a memory read and a
// check; the updates that follow are read-modify-write steps on the segment
// memory, which has one write port and one registered read port.
// One request is in service at a time. The result sits in an output
// register; while the receiver stalls, the next request is still accepted
// and worked on, but its result waits until the register empties.
// After reset the segment memory is initialised by writing slot zero; other
// slots are undefined until written, and a slot map in flip-flops records
// which slots are in use. Configuration writes take effect at once and are
// expected only while the block is idle.
module first_fit_heap_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [ffha_pkg::CfgW-1:0]   cfg_data,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  ffha_pkg::req_t              req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output ffha_pkg::rsp_t              rsp
);
    import ffha_pkg::*;

    typedef enum logic [15:0] {
        S_INIT   = 16'h0001,
        S_IDLE   = 16'h0002,
        S_WALK   = 16'h0004,
        S_CHECK  = 16'h0008,
        S_GROW   = 16'h0010,
        S_TAKE   = 16'h0020,
        S_TAKE2  = 16'h0040,
        S_TAKE3  = 16'h0080,
        S_FREE1  = 16'h0100,
        S_FREE2  = 16'h0200,
        S_MERGE  = 16'h0400,
        S_MERGE2 = 16'h0800,
        S_MERGE3 = 16'h1000,
        S_DONE   = 16'h2000,
        S_GROWR  = 16'h4000,
        S_WAITR  = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    logic [AddrW-1:0]   base_reg;
    logic [PagesW-1:0]  limit_reg;
    logic [PagesW-1:0]  pages_reg, pages_next;
    logic [SlotW-1:0]   tail_reg, tail_next;
    logic [MaxSegments-1:0] taken_reg, taken_next;

    req_t               q_reg, q_next;
    logic [LinkW-1:0]   cur_reg, cur_next;
    logic [SlotW:0]     steps_reg, steps_next;
    seg_t               seg_reg, seg_next;      // entry being worked on
    seg_t               nb_reg, nb_next;        // a neighbour entry
    logic [SlotW-1:0]   slot_reg, slot_next;
    logic [1:0]         status_reg, status_next;
    logic [AddrW-1:0]   grant_reg, grant_next;
    logic               merge_hi_reg, merge_hi_next;
    logic               rv_reg;
    rsp_t               rsp_reg;
    logic               fin;

    logic               we;
    logic [SlotW-1:0]   waddr, raddr;
    seg_t               wdata, rdata;

    ffha_seg_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Lowest free slot, as a priority search over the slot map.
    logic [LinkW-1:0] spare;
    always_comb
    begin
        spare = NullLink;
        for (int i = MaxSegments - 1; i >= 0; i--)
        begin
            if (!taken_reg[i])
            begin
                spare = LinkW'(i);
            end
        end
    end

    logic [PagesW-1:0] lim;
    assign lim = (limit_reg == '0) ? PagesW'(1) :
                 (limit_reg > PagesW'(MaxPages)) ? PagesW'(MaxPages) : limit_reg;

    // Growth arithmetic; request is 23 bits so 24 bits hold every sum.
    // The free-tail figures use the tail entry as it arrives from memory.
    logic [LenW:0]     need_free, need_new;
    logic [PagesW:0]   pg_free, pg_new;
    logic [LenW-1:0]   rest;
    logic [AddrW-1:0]  off_full;
    assign need_free = {1'b0, q_reg.request_bytes} - {1'b0, rdata.length}
                       + (LenW+1)'(PageBytes - 1);
    assign need_new  = {1'b0, q_reg.request_bytes} + (LenW+1)'(HeaderBytes + PageBytes - 1);
    assign pg_free   = (PagesW+1)'(need_free >> PageShift);
    assign pg_new    = (PagesW+1)'(need_new >> PageShift);
    assign rest      = seg_reg.length - q_reg.request_bytes;
    assign off_full  = q_reg.payload_address - base_reg - AddrW'(HeaderBytes);

    logic free_hit_ok;
    assign free_hit_ok = ({1'b0, q_reg.payload_address} >=
                          {1'b0, base_reg} + (AddrW+1)'(HeaderBytes));

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rv_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next    = state_reg;
        pages_next    = pages_reg;
        tail_next     = tail_reg;
        taken_next    = taken_reg;
        q_next        = q_reg;
        cur_next      = cur_reg;
        steps_next    = steps_reg;
        seg_next      = seg_reg;
        nb_next       = nb_reg;
        slot_next     = slot_reg;
        status_next   = status_reg;
        grant_next    = grant_reg;
        merge_hi_next = merge_hi_reg;
        we            = 1'b0;
        waddr         = slot_reg;
        wdata         = seg_reg;
        raddr         = cur_reg[SlotW-1:0];
        fin           = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                we           = 1'b1;
                waddr        = '0;
                wdata.start  = '0;
                wdata.length = LenW'(PageBytes - HeaderBytes);
                wdata.is_free = 1'b1;
                wdata.after  = NullLink;
                wdata.prev   = NullLink;
                state_next   = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    q_next      = req;
                    cur_next    = '0;
                    steps_next  = '0;
                    status_next = StatusDone;
                    grant_next  = '0;
                    raddr       = '0;
                    if (req.mode == ModeFree && !({1'b0, req.payload_address} >=
                        {1'b0, base_reg} + (AddrW+1)'(HeaderBytes)))
                    begin
                        status_next = StatusBadAddr;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_WALK:
            begin
                raddr      = cur_reg[SlotW-1:0];
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                seg_next  = rdata;
                slot_next = cur_reg[SlotW-1:0];
                steps_next = steps_reg + 1'b1;
                if (q_reg.mode == ModeAlloc)
                begin
                    if (rdata.is_free && rdata.length >= q_reg.request_bytes)
                    begin
                        state_next = S_TAKE;
                    end
                    else if (rdata.after == NullLink ||
                             steps_reg + 1'b1 == (SlotW+1)'(MaxSegments))
                    begin
                        cur_next   = {1'b0, tail_reg};
                        state_next = S_GROWR;
                    end
                    else
                    begin
                        cur_next   = rdata.after;
                        state_next = S_WALK;
                    end
                end
                else
                begin
                    if (AddrW'(rdata.start) == off_full && free_hit_ok)
                    begin
                        state_next = rdata.is_free ? S_DONE : S_FREE1;
                    end
                    else if (rdata.after == NullLink ||
                             steps_reg + 1'b1 == (SlotW+1)'(MaxSegments))
                    begin
                        status_next = StatusBadAddr;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cur_next   = rdata.after;
                        state_next = S_WALK;
                    end
                end
            end
            S_GROWR:
            begin
                raddr      = tail_reg;
                state_next = S_GROW;
            end
            S_GROW:
            begin
                seg_next  = rdata;
                slot_next = tail_reg;
                if (rdata.is_free)
                begin
                    // A page count of 2048 or more can never fit.
                    if (pg_free[PagesW] ||
                        {1'b0, pages_reg} + {1'b0, pg_free[PagesW-1:0]} > {1'b0, lim})
                    begin
                        status_next = StatusNoSpace;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        seg_next.length = rdata.length +
                            LenW'({pg_free[PagesW-1:0], PageShift'(0)});
                        pages_next = pages_reg + pg_free[PagesW-1:0];
                        we         = 1'b1;
                        waddr      = tail_reg;
                        wdata      = rdata;
                        wdata.length = seg_next.length;
                        state_next = S_TAKE;
                    end
                end
                else
                begin
                    if (spare == NullLink || {1'b0, pages_reg} + pg_new > {1'b0, lim})
                    begin
                        status_next = StatusNoSpace;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        we           = 1'b1;
                        waddr        = tail_reg;
                        wdata        = rdata;
                        wdata.after  = spare;
                        seg_next.start  = StartW'({pages_reg, PageShift'(0)});
                        seg_next.length = LenW'({pg_new, PageShift'(0)}) - LenW'(HeaderBytes);
                        seg_next.is_free = 1'b1;
                        seg_next.prev   = {1'b0, tail_reg};
                        seg_next.after  = NullLink;
                        slot_next    = spare[SlotW-1:0];
                        taken_next[spare[SlotW-1:0]] = 1'b1;
                        tail_next    = spare[SlotW-1:0];
                        pages_next   = pages_reg + pg_new[PagesW-1:0];
                        state_next   = S_TAKE;
                    end
                end
            end
            S_TAKE:
            begin
                // Split if the remainder exceeds a header and a slot is spare.
                grant_next = base_reg + AddrW'(seg_reg.start) + AddrW'(HeaderBytes);
                we    = 1'b1;
                waddr = slot_reg;
                wdata = seg_reg;
                wdata.is_free = 1'b0;
                if (rest > LenW'(HeaderBytes) && spare != NullLink)
                begin
                    wdata.length = q_reg.request_bytes;
                    wdata.after  = spare;
                    nb_next.start  = seg_reg.start + StartW'(HeaderBytes) +
                                     StartW'(q_reg.request_bytes);
                    nb_next.length = rest - LenW'(HeaderBytes);
                    nb_next.is_free = 1'b1;
                    nb_next.prev   = {1'b0, slot_reg};
                    nb_next.after  = seg_reg.after;
                    taken_next[spare[SlotW-1:0]] = 1'b1;
                    cur_next   = spare;
                    if (seg_reg.after == NullLink)
                    begin
                        tail_next = spare[SlotW-1:0];
                    end
                    state_next = S_TAKE2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_TAKE2:
            begin
                we    = 1'b1;
                waddr = cur_reg[SlotW-1:0];
                wdata = nb_reg;
                if (nb_reg.after != NullLink)
                begin
                    raddr      = nb_reg.after[SlotW-1:0];
                    state_next = S_TAKE3;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_TAKE3:
            begin
                we    = 1'b1;
                waddr = nb_reg.after[SlotW-1:0];
                wdata = rdata;
                wdata.prev = cur_reg;
                state_next = S_DONE;
            end
            S_FREE1:
            begin
                // seg_reg is the hit; mark free, fetch the previous entry.
                seg_next.is_free = 1'b1;
                we    = 1'b1;
                waddr = slot_reg;
                wdata = seg_reg;
                wdata.is_free = 1'b1;
                merge_hi_next = 1'b0;
                if (seg_reg.prev != NullLink)
                begin
                    raddr      = seg_reg.prev[SlotW-1:0];
                    state_next = S_FREE2;
                end
                else
                begin
                    merge_hi_next = 1'b1;
                    state_next    = S_MERGE;
                end
            end
            S_FREE2:
            begin
                merge_hi_next = 1'b1;
                if (rdata.is_free)
                begin
                    // Previous absorbs the hit: entry becomes lower, nb is hit.
                    nb_next   = seg_reg;
                    cur_next  = {1'b0, slot_reg};
                    seg_next  = rdata;
                    slot_next = seg_reg.prev[SlotW-1:0];
                    state_next = S_MERGE2;
                end
                else
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                // Fetch the following entry of seg_reg.
                if (seg_reg.after != NullLink)
                begin
                    raddr      = seg_reg.after[SlotW-1:0];
                    cur_next   = seg_reg.after;
                    merge_hi_next = 1'b0;
                    state_next = S_MERGE3;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MERGE3:
            begin
                if (rdata.is_free)
                begin
                    nb_next    = rdata;
                    state_next = S_MERGE2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MERGE2:
            begin
                // seg_reg absorbs nb_reg (at slot cur_reg); write, fix next's back link.
                seg_next.length = seg_reg.length + LenW'(HeaderBytes) + nb_reg.length;
                seg_next.after  = nb_reg.after;
                seg_next.is_free = 1'b1;
                we    = 1'b1;
                waddr = slot_reg;
                wdata = seg_next;
                taken_next[cur_reg[SlotW-1:0]] = 1'b0;
                if (nb_reg.after == NullLink)
                begin
                    tail_next = slot_reg;
                    state_next = merge_hi_reg ? S_MERGE : S_DONE;
                end
                else
                begin
                    raddr      = nb_reg.after[SlotW-1:0];
                    cur_next   = nb_reg.after;
                    state_next = S_WAITR;
                end
            end
            S_WAITR:
            begin
                we    = 1'b1;
                waddr = cur_reg[SlotW-1:0];
                wdata = rdata;
                wdata.prev = {1'b0, slot_reg};
                state_next = merge_hi_reg ? S_MERGE : S_DONE;
            end
            S_DONE:
            begin
                if (!rv_reg || !rsp_stall)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            base_reg  <= '0;
            limit_reg <= PagesW'(MaxPages);
            pages_reg <= PagesW'(1);
            tail_reg  <= '0;
            taken_reg <= MaxSegments'(1);
            rv_reg    <= 1'b0;
            merge_hi_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pages_reg <= pages_next;
            tail_reg  <= tail_next;
            taken_reg <= taken_next;
            merge_hi_reg <= merge_hi_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    RegBase:  base_reg  <= cfg_data;
                    RegLimit: limit_reg <= cfg_data[PagesW-1:0];
                    default:  ;
                endcase
            end
            if (fin)
            begin
                rv_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        cur_reg    <= cur_next;
        steps_reg  <= steps_next;
        seg_reg    <= seg_next;
        nb_reg     <= nb_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        grant_reg  <= grant_next;
        if (fin)
        begin
            rsp_reg.granted_address <= (status_reg == StatusDone &&
                                        q_reg.mode == ModeAlloc) ? grant_reg : '0;
            rsp_reg.status          <= status_reg;
            rsp_reg.heap_pages      <= pages_reg;
        end
    end

endmodule
